>>> hdl/bhtdh_pkg.sv
`timescale 1ns / 1ps

package bhtdh_pkg;

  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned COUNT_W    = 8;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2
  } req_type_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic hash_mul;
    logic hash_sub;
    logic hash_addr;
    logic probe;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic lookup;
    logic probe_done;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/bhtdh_req_if.sv
`timescale 1ns / 1ps

interface bhtdh_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [bhtdh_pkg::REQ_TYPE_W-1:0] req_type;
  logic        [bhtdh_pkg::KEY_W-1:0]      key;
  logic signed [bhtdh_pkg::VALUE_W-1:0]    value;
  logic        [bhtdh_pkg::SLOT_W-1:0]     target_slot;

  modport source (output valid, output req_type, output key, output value,
                  output target_slot, input ready);
  modport sink (input valid, input req_type, input key, input value,
                input target_slot, output ready);
endinterface

>>> hdl/bhtdh_rsp_if.sv
`timescale 1ns / 1ps

interface bhtdh_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 status;
  logic        [bhtdh_pkg::SLOT_W-1:0]  slot_index;
  logic signed [bhtdh_pkg::VALUE_W-1:0] found_value;
  logic        [bhtdh_pkg::COUNT_W-1:0] access_count;

  modport source (output valid, output status, output slot_index, output found_value,
                  output access_count, input ready);
  modport sink (input valid, input status, input slot_index, input found_value,
                input access_count, output ready);
endinterface

>>> hdl/bhtdh_ctrl.sv
`timescale 1ns / 1ps

module bhtdh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  bhtdh_pkg::sts_t   sts_i,
  output bhtdh_pkg::cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_HASH_MUL  = 7'b0000100,
    S_HASH_SUB  = 7'b0001000,
    S_HASH_ADDR = 7'b0010000,
    S_PROBE     = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.lookup ? S_HASH_MUL : S_FINISH;
        end
      end
      S_HASH_MUL: begin
        cmd_o.hash_mul = 1'b1;
        state_d        = S_HASH_SUB;
      end
      S_HASH_SUB: begin
        cmd_o.hash_sub = 1'b1;
        state_d        = S_HASH_ADDR;
      end
      S_HASH_ADDR: begin
        cmd_o.hash_addr = 1'b1;
        state_d         = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !req_ready_o)
    else $error("A second request was offered acceptance while one is in flight.");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !sts_i.out_free) |=> state_q == S_FINISH)
    else $error("A result was dropped while the output register was full.");

  a_probe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && !sts_i.probe_done) |=> state_q == S_PROBE)
    else $error("The probe ended before a hit or the last slot.");
`endif

endmodule

>>> hdl/bhtdh_datapath.sv
`timescale 1ns / 1ps

module bhtdh_datapath #(
  parameter int unsigned NumBuckets     = 64,
  parameter int unsigned SlotsPerBucket = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bhtdh_pkg::cmd_t                       cmd_i,
  output bhtdh_pkg::sts_t                       sts_o,
  input  logic        [bhtdh_pkg::REQ_TYPE_W-1:0] req_type_i,
  input  logic        [bhtdh_pkg::KEY_W-1:0]      key_i,
  input  logic signed [bhtdh_pkg::VALUE_W-1:0]    value_i,
  input  logic        [bhtdh_pkg::SLOT_W-1:0]     target_slot_i,
  input  logic                                  rsp_ready_i,
  output logic                                  rsp_valid_o,
  output logic                                  status_o,
  output logic        [bhtdh_pkg::SLOT_W-1:0]     slot_index_o,
  output logic signed [bhtdh_pkg::VALUE_W-1:0]    found_value_o,
  output logic        [bhtdh_pkg::COUNT_W-1:0]    access_count_o
);

  localparam int unsigned NumSlots = NumBuckets * SlotsPerBucket;
  localparam int unsigned Total    = SlotsPerBucket + NumSlots;
  localparam int unsigned AW       = $clog2(NumSlots);
  localparam int unsigned HW       = $clog2(NumBuckets);
  localparam int unsigned CW       = $clog2(Total + 1);
  localparam int unsigned KW       = bhtdh_pkg::KEY_W;
  localparam int unsigned VW       = bhtdh_pkg::VALUE_W;
  localparam int unsigned SW       = bhtdh_pkg::SLOT_W;
  localparam int unsigned XW       = KW + 2;
  localparam longint unsigned RecipWide = ((64'd1 << 32) + NumBuckets - 1) / NumBuckets;
  localparam logic [31:0] Recip = RecipWide[31:0];

  logic [bhtdh_pkg::REQ_TYPE_W-1:0] req_q;
  logic [KW-1:0]        key_q;
  logic [VW-1:0]        value_q;
  logic [SW-1:0]        tgt_q;

  logic [XW-1:0]        mix_in_q;
  logic [KW-1:0]        q1_q;
  logic [XW-1:0]        q2_q;
  logic [HW-1:0]        h1_q, mix_q;
  logic [AW-1:0]        start_q;

  logic [AW-1:0]        addr_q;
  logic [CW-1:0]        iss_q, chk_q;
  logic                 rdv_q;
  logic [AW-1:0]        rd_slot_q;
  bhtdh_pkg::entry_t    rd_word_q;

  logic                 res_hit_q;
  logic [AW-1:0]        res_slot_q;
  logic [VW-1:0]        res_val_q;
  logic [bhtdh_pkg::COUNT_W-1:0] res_cnt_q;

  logic [AW-1:0]        clr_q;
  logic                 out_valid_q;
  logic                 out_status_q;
  logic [SW-1:0]        out_slot_q;
  logic [VW-1:0]        out_found_q;
  logic [bhtdh_pkg::COUNT_W-1:0] out_cnt_q;

  bhtdh_pkg::entry_t    mem_q [NumSlots];

  logic [XW-1:0]        mix_in;
  logic [47:0]          prod1;
  logic [49:0]          prod2;
  logic [31:0]          rem1, rem2;
  logic [HW-1:0]        h2;
  logic [31:0]          base_w, start_w;
  logic                 issue;
  logic [AW-1:0]        addr_next;
  logic                 hit_now;
  logic [CW:0]          cnt_full;
  logic                 tgt_ok;
  logic [31:0]          tgt_w;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  bhtdh_pkg::entry_t    wr_word;
  logic                 res_status;
  logic [SW-1:0]        res_slot;
  logic [VW-1:0]        res_found;
  logic [bhtdh_pkg::COUNT_W-1:0] res_cnt;

  // Bucket indices use a reciprocal multiply; the error term stays below 1 / NumBuckets.
  assign mix_in = XW'({2'b00, key_q} * XW'(3) + XW'(7));
  assign prod1  = 48'(key_q) * 48'(Recip);
  assign prod2  = 50'(mix_in) * 50'(Recip);
  assign rem1   = 32'(key_q) - 32'(q1_q) * 32'(NumBuckets);
  assign rem2   = 32'(mix_in_q) - 32'(q2_q) * 32'(NumBuckets);
  assign h2     = (h1_q >= mix_q) ? (h1_q - mix_q) : (mix_q - h1_q);
  assign base_w  = 32'(h1_q) * 32'(SlotsPerBucket);
  assign start_w = 32'(h2) * 32'(SlotsPerBucket);

  assign issue = cmd_i.probe && (iss_q < CW'(Total));

  always_comb begin
    if (iss_q == CW'(SlotsPerBucket - 1)) begin
      addr_next = start_q;
    end else if (addr_q == AW'(NumSlots - 1)) begin
      addr_next = '0;
    end else begin
      addr_next = addr_q + AW'(1);
    end
  end

  always_comb begin
    if (req_q == bhtdh_pkg::REQ_SEARCH) begin
      hit_now = rd_word_q.valid && (rd_word_q.key == key_q);
    end else begin
      hit_now = !rd_word_q.valid;
    end
  end

  assign cnt_full = {1'b0, chk_q} + (CW+1)'(1);
  assign tgt_w    = 32'(tgt_q);
  assign tgt_ok   = tgt_w < 32'(NumSlots);

  assign sts_o.clear_last = clr_q == AW'(NumSlots - 1);
  assign sts_o.lookup     = (req_type_i == bhtdh_pkg::REQ_INSERT) ||
                            (req_type_i == bhtdh_pkg::REQ_SEARCH);
  assign sts_o.probe_done = rdv_q && (hit_now || (chk_q == CW'(Total - 1)));
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  always_comb begin
    res_status = 1'b1;
    res_slot   = '0;
    res_found  = '0;
    res_cnt    = '0;
    unique case (req_q)
      bhtdh_pkg::REQ_INSERT, bhtdh_pkg::REQ_SEARCH: begin
        res_cnt = res_cnt_q;
        if (res_hit_q) begin
          res_status = 1'b0;
          res_slot   = SW'(32'(res_slot_q));
          if (req_q == bhtdh_pkg::REQ_SEARCH) begin
            res_found = res_val_q;
          end
        end
      end
      bhtdh_pkg::REQ_DELETE: begin
        if (tgt_ok) begin
          res_status = 1'b0;
          res_slot   = tgt_q;
        end
      end
      default: begin
        res_status = 1'b1;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_word = '0;
    if (cmd_i.clear) begin
      wr_en = 1'b1;
    end else if (cmd_i.commit) begin
      if (req_q == bhtdh_pkg::REQ_INSERT) begin
        wr_en   = res_hit_q;
        wr_addr = res_slot_q;
        wr_word = '{valid: 1'b1, key: key_q, value: value_q};
      end else if (req_q == bhtdh_pkg::REQ_DELETE) begin
        wr_en   = tgt_ok;
        wr_addr = tgt_w[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (issue) begin
      rd_word_q <= mem_q[addr_q];
      rd_slot_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      key_q   <= key_i;
      value_q <= value_i;
      tgt_q   <= target_slot_i;
    end
    if (cmd_i.hash_mul) begin
      mix_in_q <= mix_in;
      q1_q     <= prod1[47:32];
      q2_q     <= prod2[49:32];
    end
    if (cmd_i.hash_sub) begin
      h1_q  <= rem1[HW-1:0];
      mix_q <= rem2[HW-1:0];
    end
    if (cmd_i.hash_addr) begin
      start_q <= start_w[AW-1:0];
    end
    if (cmd_i.probe && rdv_q) begin
      res_hit_q  <= hit_now;
      res_slot_q <= rd_slot_q;
      res_val_q  <= rd_word_q.value;
      res_cnt_q  <= (32'(cnt_full) > 32'd255) ? 8'hFF : bhtdh_pkg::COUNT_W'(cnt_full);
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_found_q  <= res_found;
      out_cnt_q    <= res_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      addr_q      <= '0;
      iss_q       <= '0;
      chk_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.hash_addr) begin
        addr_q <= base_w[AW-1:0];
        iss_q  <= '0;
        chk_q  <= '0;
        rdv_q  <= 1'b0;
      end else if (cmd_i.probe) begin
        rdv_q <= issue;
        if (issue) begin
          addr_q <= addr_next;
          iss_q  <= iss_q + CW'(1);
        end
        if (rdv_q) begin
          chk_q <= chk_q + CW'(1);
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_index_o   = out_slot_q;
  assign found_value_o  = out_found_q;
  assign access_count_o = out_cnt_q;

`ifndef SYNTHESIS
  a_rsp_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("A response appeared without a finished request.");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || rsp_ready_i))
    else $error("A result overwrote a response that was not taken.");

  a_checks_follow_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q <= iss_q)
    else $error("More slots were checked than were read.");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> (32'(rd_slot_q) < 32'(NumSlots)))
    else $error("A probe read fell outside the table.");
`endif

endmodule

>>> hdl/bucket_hash_table_double_hash_unit.sv
`timescale 1ns / 1ps
// An insert or search hashes its key in the hash multiply, subtract and address states, then
// probes slots through the single memory read port that reads one slot per cycle, and waits in
// the finish state until the output register is free; the next request is taken only after the
// result is committed. A delete or an unknown request goes straight to the finish state. After
// reset the table is cleared one slot per cycle, and no request is accepted until that pass ends.
module bucket_hash_table_double_hash_unit #(
  parameter int unsigned NumBuckets     = 64,
  parameter int unsigned SlotsPerBucket = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bhtdh_req_if.sink         req_i,
  bhtdh_rsp_if.source       rsp_o
);

  bhtdh_pkg::cmd_t cmd;
  bhtdh_pkg::sts_t sts;

  bhtdh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bhtdh_datapath #(
    .NumBuckets     (NumBuckets),
    .SlotsPerBucket (SlotsPerBucket)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_i.req_type),
    .key_i          (req_i.key),
    .value_i        (req_i.value),
    .target_slot_i  (req_i.target_slot),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .slot_index_o   (rsp_o.slot_index),
    .found_value_o  (rsp_o.found_value),
    .access_count_o (rsp_o.access_count)
  );

endmodule
